/* rtl/ttd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ttd_pkg;

	// Request command codes.
	typedef enum logic [1:0] {
		CMD_ATTACH_PERIODIC = 2'd0,
		CMD_ATTACH_EVENT    = 2'd1,
		CMD_MESSAGE         = 2'd2,
		CMD_TICK            = 2'd3
	} cmd_t;

	// Message that asks the scheduler to run the sender.
	localparam logic [7:0] RUN_REQUEST_TYPE = 8'd50;
	localparam logic [7:0] SCHEDULER_ID     = 8'd0;

	// Field widths of a request and a result.
	localparam int SLOT_W      = 3;
	localparam int INTERVAL_W  = 16;
	localparam int MSG_W       = 8;
	localparam int MASK_W      = 8;
	localparam int DUE_COUNT_W = 4;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WALK  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

/* rtl/ttd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ttd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/tick_task_dispatcher_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         in_valid/in_ready    command, slot, interval, msg_type, msg_receiver
// result    out        out_valid/out_ready  due_mask, due_count
//
// Attach and message requests update the slot table and then
// hand the all-zero result to the output register.
// A tick walks the table: it reads one slot table row per cycle through the
// single read port, and each valid periodic row is written back in the cycle after its read.
// Reset clears all slots at once through the valid flags; the table needs no clearing pass.
// A stalled result waits in the output register while the next request is processed.

module tick_task_dispatcher_top import ttd_pkg::*; #(
	parameter int SLOTS         = 8,
	parameter int INTERVAL_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [1:0]             command,
	input  wire logic [SLOT_W-1:0]      slot,
	input  wire logic [INTERVAL_W-1:0]  interval,
	input  wire logic [MSG_W-1:0]       msg_type,
	input  wire logic [MSG_W-1:0]       msg_receiver,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [MASK_W-1:0]           due_mask,
	output logic [DUE_COUNT_W-1:0]      due_count
);

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENTRY_W = 1 + 2 * INTERVAL_BITS;

	state_t state_q;

	logic [SLOTS-1:0] slot_valid_q;
	logic [SLOTS-1:0] run_pending_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [MASK_W-1:0]      res_mask_q;
	logic [DUE_COUNT_W-1:0] res_count_q;

	logic                   out_valid_q;
	logic [MASK_W-1:0]      due_mask_q;
	logic [DUE_COUNT_W-1:0] due_count_q;

	cmd_t             cmd;
	logic             accept;
	logic             slot_in_range;
	logic [IDX_W-1:0] slot_idx;
	logic             is_attach;
	logic             run_request;
	logic             out_free;

	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic                     ram_re;
	logic [ENTRY_W-1:0]       ram_rdata;

	logic                     row_periodic;
	logic [INTERVAL_BITS-1:0] row_limit;
	logic [INTERVAL_BITS-1:0] row_count;
	logic [INTERVAL_BITS-1:0] count_inc;
	logic [INTERVAL_BITS-1:0] count_next;
	logic                     row_valid;
	logic                     row_pending;
	logic                     row_due;
	logic                     row_writeback;
	logic                     row_clear_pending;
	logic [MASK_W-1:0]        due_bit;

	// Request decode.
	assign cmd           = cmd_t'(command);
	assign in_ready      = (state_q == ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign slot_in_range = (32'(slot) < SLOTS);
	assign slot_idx      = IDX_W'(slot);
	assign is_attach     = (cmd == CMD_ATTACH_PERIODIC) || (cmd == CMD_ATTACH_EVENT);
	assign run_request   = (cmd == CMD_MESSAGE) && (msg_type == RUN_REQUEST_TYPE) &&
	                       (msg_receiver == SCHEDULER_ID) && slot_in_range &&
	                       slot_valid_q[slot_idx];
	assign out_free      = !out_valid_q || out_ready;

	// Row layout: periodic flag, limit, running counter.
	assign row_periodic = ram_rdata[ENTRY_W-1];
	assign row_limit    = ram_rdata[2*INTERVAL_BITS-1:INTERVAL_BITS];
	assign row_count    = ram_rdata[INTERVAL_BITS-1:0];

	// Per-slot tick evaluation on the row read in the previous cycle.
	always_comb begin
		row_valid         = vld_s1 && slot_valid_q[idx_s1];
		row_pending       = run_pending_q[idx_s1];
		count_inc         = row_count + INTERVAL_BITS'(1);
		count_next        = (count_inc > row_limit) ? '0 : count_inc;
		row_due           = row_valid && (row_periodic ? (row_count == '0) : row_pending);
		row_writeback     = row_valid && row_periodic;
		row_clear_pending = row_valid && !row_periodic && row_pending;
		due_bit           = row_due ? (MASK_W'(1) << idx_s1) : '0;
	end

	// Table write port: attach outside a tick, counter write-back during a tick.
	always_comb begin
		if (vld_s1) begin
			ram_we    = row_writeback;
			ram_waddr = idx_s1;
			ram_wdata = {1'b1, row_limit, count_next};
		end else begin
			ram_we    = accept && is_attach && slot_in_range;
			ram_waddr = slot_idx;
			ram_wdata = {(cmd == CMD_ATTACH_PERIODIC),
			             (cmd == CMD_ATTACH_PERIODIC) ? INTERVAL_BITS'(interval) : '0,
			             {INTERVAL_BITS{1'b0}}};
		end
	end

	assign ram_re = (state_q == ST_WALK);

	ttd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// Sequencer, slot flags and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_valid_q  <= '0;
			run_pending_q <= '0;
			rd_idx_q      <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
		end else begin
			vld_s1 <= (state_q == ST_WALK);
			idx_s1 <= rd_idx_q;
			if (row_clear_pending) begin
				run_pending_q[idx_s1] <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						if (cmd == CMD_TICK) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_DONE;
							if (is_attach && slot_in_range) begin
								slot_valid_q[slot_idx] <= 1'b1;
							end
							if (run_request) begin
								run_pending_q[slot_idx] <= 1'b1;
							end
						end
					end
				end
				ST_WALK: begin
					if (rd_idx_q == IDX_W'(SLOTS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result accumulation over the walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_mask_q  <= '0;
			res_count_q <= '0;
		end else if (row_due) begin
			res_mask_q  <= res_mask_q | due_bit;
			res_count_q <= res_count_q + DUE_COUNT_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			due_mask_q  <= res_mask_q;
			due_count_q <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign due_mask  = due_mask_q;
	assign due_count = due_count_q;

endmodule

`default_nettype wire

/* tb/tb_tick_task_dispatcher_top.sv */
`timescale 1ns / 1ps

module tb_tick_task_dispatcher_top;
	import ttd_pkg::*;

	localparam int NUM_SLOTS      = 8;
	localparam int RANDOM_ITEMS   = 424;
	localparam int PRESSURE_AT    = 60;
	localparam int PRESSURE_HOLD  = 400;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	// One request as it is put on the input channel.
	typedef struct packed {
		cmd_t                  cmd;
		logic [SLOT_W-1:0]     slot;
		logic [INTERVAL_W-1:0] interval;
		logic [MSG_W-1:0]      msg_type;
		logic [MSG_W-1:0]      msg_receiver;
	} req_t;

	// One result: which slots run this tick and how many.
	typedef struct packed {
		logic [MASK_W-1:0]      mask;
		logic [DUE_COUNT_W-1:0] count;
	} due_result_t;

	// A directed request, with its result written out where it is obvious.
	typedef struct {
		req_t        req;
		bit          typed;
		due_result_t due;
	} directed_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	cmd_t                  command;
	logic [SLOT_W-1:0]     slot;
	logic [INTERVAL_W-1:0] interval;
	logic [MSG_W-1:0]      msg_type;
	logic [MSG_W-1:0]      msg_receiver;
	logic                  out_valid;
	logic                  out_ready;
	logic [MASK_W-1:0]     due_mask;
	logic [DUE_COUNT_W-1:0] due_count;

	// Written-out result travels with the request it belongs to.
	bit          typed_known;
	due_result_t typed_due;

	// Shadow copy of the slot table.
	bit                    slot_used     [NUM_SLOTS];
	bit                    slot_periodic [NUM_SLOTS];
	logic [INTERVAL_W-1:0] slot_limit    [NUM_SLOTS];
	logic [INTERVAL_W-1:0] slot_counter  [NUM_SLOTS];
	bit                    slot_run_req  [NUM_SLOTS];

	due_result_t awaited_due_q[$];
	int          mismatch_count;
	int          requests_sent;
	int          results_taken;
	int unsigned cycle_count;

	directed_row_t directed [26] = '{
		// Tick on an empty table.
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		// Attach at the interval extremes and an event slot with a request.
		'{'{CMD_ATTACH_PERIODIC, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_ATTACH_PERIODIC, 3'd7, 16'hFFFF, 8'd255, 8'd255}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_ATTACH_EVENT, 3'd3, 16'hFFFF, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_MESSAGE, 3'd3, 16'h0000, 8'd50, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd7, 16'hFFFF, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		// Messages that must be ignored: empty slot, wrong type, wrong receiver.
		'{'{CMD_MESSAGE, 3'd5, 16'h0000, 8'd50, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_MESSAGE, 3'd3, 16'h0000, 8'd49, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_MESSAGE, 3'd3, 16'h0000, 8'd50, 8'd255}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_MESSAGE, 3'd3, 16'hFFFF, 8'd255, 8'd1}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		// A request on a periodic slot is kept and shows up after an event attach.
		'{'{CMD_MESSAGE, 3'd0, 16'h0000, 8'd50, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		'{'{CMD_ATTACH_EVENT, 3'd0, 16'h1234, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		// A period of three ticks.
		'{'{CMD_ATTACH_PERIODIC, 3'd1, 16'h0002, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}},
		// Re-attaching keeps a request across a change of kind.
		'{'{CMD_ATTACH_EVENT, 3'd6, 16'h0000, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_MESSAGE, 3'd6, 16'h0000, 8'd50, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_ATTACH_PERIODIC, 3'd6, 16'h0001, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_ATTACH_EVENT, 3'd6, 16'h0000, 8'd0, 8'd0}, 1'b1, '{8'h00, 4'd0}},
		'{'{CMD_TICK, 3'd0, 16'h0000, 8'd0, 8'd0}, 1'b0, '{8'h00, 4'd0}}
	};

	tick_task_dispatcher_top #(
		.SLOTS        (NUM_SLOTS),
		.INTERVAL_BITS(INTERVAL_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.slot        (slot),
		.interval    (interval),
		.msg_type    (msg_type),
		.msg_receiver(msg_receiver),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.due_mask    (due_mask),
		.due_count   (due_count)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one request to the shadow table and return the result it produces.
	function automatic due_result_t compute_due(input req_t r);
		due_result_t           res;
		bit                    hit;
		logic [INTERVAL_W-1:0] next_count;
		res = '0;
		case (r.cmd)
			CMD_ATTACH_PERIODIC, CMD_ATTACH_EVENT: begin
				slot_used[r.slot]     = 1'b1;
				slot_periodic[r.slot] = (r.cmd == CMD_ATTACH_PERIODIC);
				slot_limit[r.slot]    = (r.cmd == CMD_ATTACH_PERIODIC) ? r.interval : '0;
				slot_counter[r.slot]  = '0;
			end
			CMD_MESSAGE: begin
				if (r.msg_type == RUN_REQUEST_TYPE && r.msg_receiver == SCHEDULER_ID &&
				    slot_used[r.slot])
					slot_run_req[r.slot] = 1'b1;
			end
			default: begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					hit = 1'b0;
					if (slot_used[s]) begin
						if (slot_periodic[s]) begin
							hit = (slot_counter[s] == '0);
							next_count = slot_counter[s] + 1'b1;
							if (next_count > slot_limit[s])
								next_count = '0;
							slot_counter[s] = next_count;
						end else if (slot_run_req[s]) begin
							hit = 1'b1;
							slot_run_req[s] = 1'b0;
						end
					end
					if (hit) begin
						res.mask[s] = 1'b1;
						res.count = res.count + 1'b1;
					end
				end
			end
		endcase
		return res;
	endfunction

	// Mostly well-formed traffic: ticks, attaches and run requests to random slots.
	function automatic req_t random_request();
		req_t r;
		int   pick;
		r.slot         = SLOT_W'($urandom);
		r.interval     = INTERVAL_W'($urandom);
		r.msg_type     = MSG_W'($urandom);
		r.msg_receiver = MSG_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			r.cmd = CMD_TICK;
		end else if (pick < 70) begin
			r.cmd = CMD_MESSAGE;
			if ($urandom_range(0, 3) != 0) begin
				r.msg_type     = RUN_REQUEST_TYPE;
				r.msg_receiver = SCHEDULER_ID;
			end
		end else begin
			r.cmd = (pick < 85) ? CMD_ATTACH_PERIODIC : CMD_ATTACH_EVENT;
			// Short periods keep periodic slots firing; a few long ones for range.
			if ($urandom_range(0, 9) != 0)
				r.interval = INTERVAL_W'($urandom_range(0, 6));
		end
		return r;
	endfunction

	// Wait drawn per item, with bands of back-to-back traffic.
	function automatic int draw_gap(input int idx);
		if ((idx / 40) % 3 == 2)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
	endtask

	// Offer one request after an idle gap and hold it until it is taken.
	task automatic offer_request(input req_t r, input bit typed, input due_result_t due);
		int gap;
		gap = draw_gap(requests_sent);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= r.cmd;
		slot         <= r.slot;
		interval     <= r.interval;
		msg_type     <= r.msg_type;
		msg_receiver <= r.msg_receiver;
		typed_known  <= typed;
		typed_due    <= due;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// Result side: random stalls, stretches of none, and one long hold-off.
	initial begin : result_sink
		int hold;
		out_ready = 1'b0;
		results_taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_taken == PRESSURE_AT)
				hold = PRESSURE_HOLD;
			else if ((results_taken / 40) % 3 == 2)
				hold = 0;
			else
				hold = $urandom_range(0, 13);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

	// Compare each result with the oldest expectation, then record new requests.
	always @(posedge clk) begin : scoreboard
		due_result_t want;
		req_t        seen;
		if (out_valid && out_ready) begin
			if (awaited_due_q.size() == 0) begin
				note_mismatch("unexpected result, due_mask", 8'h00, due_mask);
			end else begin
				want = awaited_due_q.pop_front();
				if (due_mask !== want.mask)
					note_mismatch("due_mask", want.mask, due_mask);
				if (due_count !== want.count)
					note_mismatch("due_count", 8'(want.count), 8'(due_count));
			end
		end
		if (in_valid && in_ready) begin
			seen = '{command, slot, interval, msg_type, msg_receiver};
			want = compute_due(seen);
			if (typed_known)
				want = typed_due;
			awaited_due_q.push_back(want);
		end
	end

	// Watchdog.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		req_t r;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		command        = CMD_TICK;
		slot           = '0;
		interval       = '0;
		msg_type       = '0;
		msg_receiver   = '0;
		typed_known    = 1'b0;
		typed_due      = '0;
		mismatch_count = 0;
		requests_sent  = 0;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			slot_used[s]     = 1'b0;
			slot_periodic[s] = 1'b0;
			slot_limit[s]    = '0;
			slot_counter[s]  = '0;
			slot_run_req[s]  = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (directed[i])
			offer_request(directed[i].req, directed[i].typed, directed[i].due);

		// Random traffic.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = random_request();
			offer_request(r, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Drain and let any stray result show up.
		while (awaited_due_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
